FILE: hw/rtl/magic_length_prefixed_deframer_macros.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Concurrent assertion forms for the deframer port checker.
// ----------------------------------------------------------------------------
`ifndef MAGIC_LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`define MAGIC_LENGTH_PREFIXED_DEFRAMER_MACROS_SVH

// Checked at every edge after reset is released.
`define MLPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define MLPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/mlpd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Widths, frame constants and phase codes of the length-prefixed deframer.
// ----------------------------------------------------------------------------
package mlpd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenDigits = 14;
  localparam int unsigned CountBits = 32;
  localparam int unsigned MagicLen  = 5;

  localparam int unsigned MatchW = $clog2(MagicLen + 1);
  localparam int unsigned DigitW = $clog2(LenDigits + 1);
  localparam int unsigned ProdW  = CountBits + 4;

  localparam logic [ByteW-1:0] MagicWord [MagicLen] = '{
    8'h49, 8'h44, 8'h4F, 8'h4F, 8'h52
  };

  localparam logic [ByteW-1:0] AsciiZero = 8'h30;
  localparam logic [ByteW-1:0] AsciiNine = 8'h39;

  localparam logic [1:0] PhHunt = 2'd0;
  localparam logic [1:0] PhSep  = 2'd1;
  localparam logic [1:0] PhLen  = 2'd2;
  localparam logic [1:0] PhPay  = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             frame_last;
    logic             empty_frame;
  } res_t;

endpackage

FILE: hw/rtl/mlpd_if.sv
// ----------------------------------------------------------------------------
// Deframer channel interfaces
// Valid/ready channels for received bytes and for deframed results.
// ----------------------------------------------------------------------------
interface mlpd_rx_if;
  logic                        valid;
  logic                        ready;
  logic [mlpd_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mlpd_res_if;
  logic                        valid;
  logic                        ready;
  logic [mlpd_pkg::ByteW-1:0]  payload_byte;
  logic                        frame_last;
  logic                        empty_frame;

  modport source (output valid, output payload_byte, output frame_last, output empty_frame,
                  input ready);
  modport sink (input valid, input payload_byte, input frame_last, input empty_frame,
                output ready);
endinterface

FILE: hw/rtl/magic_length_prefixed_deframer.sv
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer
// Hunts for the magic word, skips one separator, reads a fixed-width decimal
// length and forwards that many payload bytes with a last marker.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle while input ready is high, and each
// result is registered in the output stage. The sustained rate is one byte per
// cycle as long as the result sink keeps ready high; it is set by the state
// update done for each byte (a magic compare, a multiply-by-ten add or a count
// decrement). A two-entry output stage holds results, so a byte is still taken
// while one result waits, and input ready drops only when both entries are
// full. A zero or invalid length gives one result flagged empty on the last
// length digit. There is no clearing pass after reset.
module magic_length_prefixed_deframer (
  input  logic              clk_i,
  input  logic              rst_ni,
  mlpd_rx_if.sink           rx_i,
  mlpd_res_if.source        res_o
);

  logic [1:0]                      phase_q, phase_d;
  logic [mlpd_pkg::MatchW-1:0]     matched_q, matched_d, match_nxt;
  logic [mlpd_pkg::DigitW-1:0]     digits_q, digits_d;
  logic [mlpd_pkg::CountBits-1:0]  accum_q, accum_d;
  logic                            bad_q, bad_d;
  logic [mlpd_pkg::CountBits-1:0]  left_q, left_d;

  logic                            in_acc;
  logic                            is_digit;
  logic [mlpd_pkg::ProdW-1:0]      prod;
  logic                            res_valid;
  mlpd_pkg::res_t                  res;

  logic                            out_valid_q, skid_valid_q;
  mlpd_pkg::res_t                  out_q, skid_q;
  logic                            out_free;

  assign rx_i.ready = !skid_valid_q;
  assign in_acc     = rx_i.valid && rx_i.ready;

  assign is_digit = (rx_i.rx_byte >= mlpd_pkg::AsciiZero) &&
                    (rx_i.rx_byte <= mlpd_pkg::AsciiNine);
  assign prod = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} +
                mlpd_pkg::ProdW'(rx_i.rx_byte[3:0]);

  always_comb begin
    phase_d   = phase_q;
    matched_d = matched_q;
    digits_d  = digits_q;
    accum_d   = accum_q;
    bad_d     = bad_q;
    left_d    = left_q;
    match_nxt = '0;
    res_valid = 1'b0;
    res       = '0;
    if (in_acc) begin
      case (phase_q)
        mlpd_pkg::PhHunt: begin
          if (rx_i.rx_byte == mlpd_pkg::MagicWord[matched_q]) begin
            match_nxt = matched_q + 1'b1;
          end else if (rx_i.rx_byte == mlpd_pkg::MagicWord[0]) begin
            match_nxt = mlpd_pkg::MatchW'(1);
          end else begin
            match_nxt = '0;
          end
          if (match_nxt == mlpd_pkg::MatchW'(mlpd_pkg::MagicLen)) begin
            matched_d = '0;
            phase_d   = mlpd_pkg::PhSep;
          end else begin
            matched_d = match_nxt;
          end
        end
        mlpd_pkg::PhSep: begin
          digits_d = '0;
          accum_d  = '0;
          bad_d    = 1'b0;
          phase_d  = mlpd_pkg::PhLen;
        end
        mlpd_pkg::PhLen: begin
          if (!is_digit) begin
            bad_d = 1'b1;
          end else if (!bad_q) begin
            accum_d = prod[mlpd_pkg::CountBits-1:0];
            if (|prod[mlpd_pkg::ProdW-1:mlpd_pkg::CountBits]) begin
              bad_d = 1'b1;
            end
          end
          digits_d = digits_q + 1'b1;
          if (digits_q == mlpd_pkg::DigitW'(mlpd_pkg::LenDigits - 1)) begin
            digits_d = '0;
            if (bad_d || (accum_d == '0)) begin
              phase_d          = mlpd_pkg::PhHunt;
              accum_d          = '0;
              bad_d            = 1'b0;
              res_valid        = 1'b1;
              res.frame_last   = 1'b1;
              res.empty_frame  = 1'b1;
            end else begin
              left_d  = accum_d;
              accum_d = '0;
              phase_d = mlpd_pkg::PhPay;
            end
          end
        end
        default: begin
          res_valid        = 1'b1;
          res.payload_byte = rx_i.rx_byte;
          if (left_q <= mlpd_pkg::CountBits'(1)) begin
            left_d         = '0;
            phase_d        = mlpd_pkg::PhHunt;
            res.frame_last = 1'b1;
          end else begin
            left_d = left_q - 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mlpd_pkg::PhHunt;
      matched_q <= '0;
      digits_q  <= '0;
      accum_q   <= '0;
      bad_q     <= 1'b0;
      left_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      matched_q <= matched_d;
      digits_q  <= digits_d;
      accum_q   <= accum_d;
      bad_q     <= bad_d;
      left_q    <= left_d;
    end
  end

  // The skid entry fills only while the output entry is held; input ready
  // is low whenever the skid entry is full.
  assign out_free = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || res_valid;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.payload_byte = out_q.payload_byte;
  assign res_o.frame_last   = out_q.frame_last;
  assign res_o.empty_frame  = out_q.empty_frame;

endmodule

FILE: hw/rtl/mlpd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Watches the result channel of the deframer over time.
// ----------------------------------------------------------------------------
`include "magic_length_prefixed_deframer_macros.svh"

module mlpd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [mlpd_pkg::ByteW-1:0]  payload_byte_i,
  input logic                        frame_last_i,
  input logic                        empty_frame_i
);

  logic                        empty_res;
  logic                        stalled;
  logic [mlpd_pkg::ByteW+1:0]  res_bits;

  assign empty_res = res_valid_i && empty_frame_i;
  assign stalled   = res_valid_i && !res_ready_i;
  assign res_bits  = {payload_byte_i, frame_last_i, empty_frame_i};

  `MLPD_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !res_valid_i, "result valid in reset")
  `MLPD_ASSERT(a_empty_is_last, empty_res |-> frame_last_i, "empty frame not marked last")
  `MLPD_ASSERT(a_empty_zero_byte, empty_res |-> payload_byte_i == '0, "empty frame carries data")
  `MLPD_ASSERT(a_valid_held, stalled |=> res_valid_i, "result transaction dropped")
  `MLPD_ASSERT(a_payload_held, stalled |=> $stable(res_bits), "stalled result changed")

endmodule

bind magic_length_prefixed_deframer mlpd_checker u_mlpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .payload_byte_i (res_o.payload_byte),
  .frame_last_i   (res_o.frame_last),
  .empty_frame_i  (res_o.empty_frame)
);

FILE: bench/mlpd_deframe_checker.sv
// ----------------------------------------------------------------------------
// Deframer result checker
// Watches both channels of the length-prefixed deframer. Every accepted byte
// is run through a local copy of the deframing state machine, and every
// accepted result is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module mlpd_deframe_checker
  import mlpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mlpd_rx_if          rx_i,
  mlpd_res_if         res_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_cnt_o,
  output int unsigned bytes_cnt_o,
  output int unsigned frames_cnt_o,
  output int unsigned empty_cnt_o,
  output int unsigned payload_cnt_o
);

  logic [1:0]           phase_q;
  logic [MatchW-1:0]    magic_cnt;
  logic [DigitW-1:0]    digit_cnt;
  logic [CountBits:0]   len_acc;
  logic                 len_bad;
  logic [CountBits-1:0] bytes_left;
  res_t                 expected_results[$];

  function automatic bit deframe_byte(input logic [ByteW-1:0] b, output res_t r);
    logic [CountBits+4:0] wide;
    bit hit;
    hit = 1'b0;
    r = '0;
    case (phase_q)
      PhHunt: begin
        if (magic_cnt < MagicLen && b == MagicWord[magic_cnt]) begin
          magic_cnt = magic_cnt + 1'b1;
        end else begin
          magic_cnt = (b == MagicWord[0]) ? MatchW'(1) : '0;
        end
        if (magic_cnt >= MagicLen) begin
          magic_cnt = '0;
          phase_q = PhSep;
        end
      end
      PhSep: begin
        digit_cnt = '0;
        len_acc = '0;
        len_bad = 1'b0;
        phase_q = PhLen;
      end
      PhLen: begin
        if (b < AsciiZero || b > AsciiNine) begin
          len_bad = 1'b1;
        end else if (!len_bad) begin
          wide = len_acc * 10 + (b - AsciiZero);
          if (wide[CountBits+4:CountBits] != '0) begin
            len_bad = 1'b1;
          end
          len_acc = wide[CountBits:0];
        end
        digit_cnt = digit_cnt + 1'b1;
        if (digit_cnt >= LenDigits) begin
          digit_cnt = '0;
          if (len_bad || len_acc == '0) begin
            phase_q = PhHunt;
            len_acc = '0;
            len_bad = 1'b0;
            r.frame_last = 1'b1;
            r.empty_frame = 1'b1;
            hit = 1'b1;
          end else begin
            bytes_left = len_acc[CountBits-1:0];
            len_acc = '0;
            phase_q = PhPay;
          end
        end
      end
      default: begin
        r.payload_byte = b;
        if (bytes_left <= 1) begin
          bytes_left = '0;
          phase_q = PhHunt;
          r.frame_last = 1'b1;
        end else begin
          bytes_left = bytes_left - 1'b1;
        end
        hit = 1'b1;
      end
    endcase
    return hit;
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t want_r;
    res_t got_r;
    if (!rst_ni) begin
      phase_q = PhHunt;
      magic_cnt = '0;
      digit_cnt = '0;
      len_acc = '0;
      len_bad = 1'b0;
      bytes_left = '0;
      expected_results.delete();
      mismatch_cnt_o = 0;
      pending_cnt_o = 0;
      bytes_cnt_o = 0;
      frames_cnt_o = 0;
      empty_cnt_o = 0;
      payload_cnt_o = 0;
    end else begin
      if (rx_i.valid && rx_i.ready) begin
        bytes_cnt_o++;
        if (deframe_byte(rx_i.rx_byte, want_r)) begin
          expected_results.push_back(want_r);
        end
      end
      if (res_i.valid && res_i.ready) begin
        got_r.payload_byte = res_i.payload_byte;
        got_r.frame_last = res_i.frame_last;
        got_r.empty_frame = res_i.empty_frame;
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with none expected, expected nothing, actual %0h",
                   $time, got_r);
          mismatch_cnt_o++;
        end else begin
          want_r = expected_results.pop_front();
          compare_field("empty_frame", want_r.empty_frame, got_r.empty_frame);
          compare_field("frame_last", want_r.frame_last, got_r.frame_last);
          if (!want_r.empty_frame) begin
            compare_field("payload_byte", want_r.payload_byte, got_r.payload_byte);
            payload_cnt_o++;
          end else begin
            empty_cnt_o++;
          end
          if (want_r.frame_last) begin
            frames_cnt_o++;
          end
        end
      end
      pending_cnt_o = expected_results.size();
    end
  end

endmodule

FILE: bench/magic_length_prefixed_deframer_tb.sv
// ----------------------------------------------------------------------------
// Length-prefixed deframer testbench
// Sends a short fixed frame and then a stream of random frames: noise and
// partial magic words between frames, random separators, valid, zero,
// non-numeric and oversized length fields, and payloads that hold magic
// characters. Both channels stall at random; a separate checker predicts and
// compares every result transaction.
// ----------------------------------------------------------------------------
module magic_length_prefixed_deframer_tb;
  import mlpd_pkg::*;

  localparam int unsigned NumBytes    = 1550;
  localparam int unsigned CalmBytes   = 250;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 20;

  localparam logic [ByteW-1:0] SpaceChar = 8'h20;
  localparam logic [ByteW-1:0] PlusChar  = 8'h2B;
  localparam logic [ByteW-1:0] MinusChar = 8'h2D;

  logic clk_i;
  logic rst_ni;

  mlpd_rx_if  rx_ch();
  mlpd_res_if res_ch();

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned bytes_cnt;
  int unsigned frames_cnt;
  int unsigned empty_cnt;
  int unsigned payload_cnt;
  int unsigned sent_cnt;
  int unsigned idle_pct;
  int unsigned stall_cycles = 0;
  bit          calm;

  magic_length_prefixed_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .res_o  (res_ch)
  );

  mlpd_deframe_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_i           (rx_ch),
    .res_i          (res_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt),
    .bytes_cnt_o    (bytes_cnt),
    .frames_cnt_o   (frames_cnt),
    .empty_cnt_o    (empty_cnt),
    .payload_cnt_o  (payload_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("magic_length_prefixed_deframer_tb NOT OK");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : sink_ready
    int unsigned hold;
    hold = 0;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold == 0 && !calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        hold = $urandom_range(1, 5);
      end
      if (hold != 0) begin
        res_ch.ready <= 1'b0;
        hold--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent_cnt++;
    calm = (sent_cnt + CalmBytes >= NumBytes);
  endtask

  task automatic send_frame();
    int unsigned      kind;
    int unsigned      noise_len;
    int unsigned      pay_len;
    int unsigned      run_len;
    logic [63:0]      len_val;
    logic [ByteW-1:0] bad_char;
    logic [ByteW-1:0] digits [LenDigits];
    kind = $urandom_range(0, 9);
    idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 10 * $urandom_range(1, 4);
    noise_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
    for (int i = 0; i < noise_len; i++) begin
      case ($urandom_range(0, 3))
        0: send_byte(MagicWord[$urandom_range(0, MagicLen - 1)]);
        1: begin
          run_len = $urandom_range(1, MagicLen - 1);
          for (int j = 0; j < run_len; j++) send_byte(MagicWord[j]);
        end
        default: send_byte(ByteW'($urandom_range(0, 255)));
      endcase
    end

    if (kind <= 5) begin
      len_val = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    end else if (kind == 8) begin
      case ($urandom_range(0, 2))
        0: len_val = 64'd4294967296;
        1: len_val = 64'd99999999999999;
        default: len_val = 64'd4294967296 +
                           ({$urandom, $urandom} % (64'd100000000000000 - 64'd4294967296));
      endcase
    end else if (kind == 7) begin
      len_val = $urandom_range(0, 100000);
    end else begin
      len_val = 0;
    end
    for (int i = LenDigits - 1; i >= 0; i--) begin
      digits[i] = AsciiZero + ByteW'(len_val % 64'd10);
      len_val = len_val / 64'd10;
    end
    if (kind == 7 || kind == 9) begin
      case ($urandom_range(0, 5))
        0: bad_char = SpaceChar;
        1: bad_char = PlusChar;
        2: bad_char = MinusChar;
        3: bad_char = AsciiZero - 1'b1;
        4: bad_char = AsciiNine + 1'b1;
        default: begin
          bad_char = ByteW'($urandom_range(0, 255));
          while (bad_char >= AsciiZero && bad_char <= AsciiNine) begin
            bad_char = ByteW'($urandom_range(0, 255));
          end
        end
      endcase
      digits[$urandom_range(0, LenDigits - 1)] = bad_char;
    end
    pay_len = 0;
    if (kind <= 5) begin
      for (int i = 0; i < LenDigits; i++) pay_len = pay_len * 10 + (digits[i] - AsciiZero);
    end

    for (int i = 0; i < MagicLen; i++) send_byte(MagicWord[i]);
    send_byte(ByteW'($urandom_range(0, 255)));
    for (int i = 0; i < LenDigits; i++) send_byte(digits[i]);
    for (int i = 0; i < pay_len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        send_byte(MagicWord[i % MagicLen]);
      end else begin
        send_byte(ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    sent_cnt = 0;
    idle_pct = 0;
    calm = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A stray first magic character, then a two-byte frame with extreme bytes.
    send_byte(MagicWord[0]);
    for (int i = 0; i < MagicLen; i++) send_byte(MagicWord[i]);
    send_byte(8'hFF);
    for (int i = 0; i < LenDigits - 1; i++) send_byte(AsciiZero);
    send_byte(AsciiZero + 8'd2);
    send_byte(8'h00);
    send_byte(8'hFF);

    while (sent_cnt < NumBytes) send_frame();

    rx_ch.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Run covered %0d received bytes and %0d frames, %0d of them empty or invalid.",
             bytes_cnt, frames_cnt, empty_cnt);
    $display("%0d payload bytes were checked, %0d mismatches found.", payload_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("magic_length_prefixed_deframer_tb OK");
    end else begin
      $display("magic_length_prefixed_deframer_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mlpd_pkg.sv
hw/rtl/mlpd_if.sv
hw/rtl/magic_length_prefixed_deframer.sv
hw/rtl/mlpd_checker.sv
bench/mlpd_deframe_checker.sv
bench/magic_length_prefixed_deframer_tb.sv
